>>> hw/rtl/lps_pkg.sv
// ============================================================================
// lps_pkg - LED pattern sequencer shared types
// Pattern codes, controller states and the command/status bundles.
// ============================================================================
package lps_pkg;

    // word width of the LED frame
    localparam int WordBits = 8;

    typedef enum logic [2:0] {
        FUNC_FLASH  = 3'd0,
        FUNC_FILL   = 3'd1,
        FUNC_EMPTY  = 3'd2,
        FUNC_TRAVEL = 3'd3,
        FUNC_CLIMB  = 3'd4
    } lps_func_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } lps_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // capture command beat, apply load
        logic step;     // produce one frame
    } lps_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pattern_ok;   // incoming func is a real pattern
        logic out_free;     // output register can take a frame this cycle
        logic final_frame;  // frame of this step closes the command
    } lps_stat_t;

endpackage

>>> hw/rtl/lps_ctrl.sv
// ============================================================================
// lps_ctrl - LED pattern sequencer controller
// Two-state machine: waits for a command beat, then steps frames out if it holds a real pattern.
// ============================================================================
module lps_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  lps_pkg::lps_stat_t stat,
    output lps_pkg::lps_cmd_t  cmd
);

    lps_pkg::lps_state_t state_reg;
    lps_pkg::lps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && stat.pattern_ok)
                begin
                    state_next = lps_pkg::ST_RUN;
                end
            end
            lps_pkg::ST_RUN:
            begin
                if (stat.out_free && stat.final_frame)
                begin
                    state_next = lps_pkg::ST_IDLE;
                end
            end
            default: state_next = lps_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.accept    = s_axis_tvalid;
            end
            lps_pkg::ST_RUN:
            begin
                cmd.step = stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/lps_dp.sv
// ============================================================================
// lps_dp - LED pattern sequencer datapath
// Kept LED word, sweep counters, frame generation and output register.
// ============================================================================
module lps_dp
#(
    parameter int LED_COUNT = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [23:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast,
    input  lps_pkg::lps_cmd_t  cmd,
    output lps_pkg::lps_stat_t stat
);

    // usable LEDs: the configured count, never more than the word holds
    localparam int  LimitInt = (LED_COUNT < lps_pkg::WordBits) ? LED_COUNT
                                                                : lps_pkg::WordBits;
    localparam logic [3:0] Limit = 4'(LimitInt);

    // command beat fields
    lps_pkg::lps_func_t in_func;
    logic               in_reverse;
    logic [3:0]         in_width;
    logic               in_load;
    logic [7:0]         in_start;
    logic [3:0]         in_n;

    assign in_func    = lps_pkg::lps_func_t'(s_axis_tdata[2:0]);
    assign in_reverse = s_axis_tdata[3];
    assign in_width   = s_axis_tdata[7:4];
    assign in_load    = s_axis_tdata[8];
    assign in_start   = s_axis_tdata[16:9];
    assign in_n       = (in_width == 4'd0 || in_width > Limit) ? Limit : in_width;

    lps_pkg::lps_func_t func_reg;
    logic               rev_reg;
    logic [3:0]         n_reg;
    logic [7:0]         word_reg, word_next;
    logic [3:0]         outer_reg, outer_next;
    logic [3:0]         inner_reg, inner_next;
    logic               out_valid_reg;
    logic [7:0]         out_leds_reg;
    logic               out_last_reg;

    logic [7:0] frame;
    logic       final_frame;
    logic       pattern_ok;
    logic [3:0] pos_wide;
    logic [7:0] bit_sel;
    logic [7:0] mask;
    logic       sweep_end;

    always_comb
    begin
        case (in_func)
            lps_pkg::FUNC_FLASH, lps_pkg::FUNC_FILL, lps_pkg::FUNC_EMPTY,
            lps_pkg::FUNC_TRAVEL, lps_pkg::FUNC_CLIMB: pattern_ok = 1'b1;
            default:                                   pattern_ok = 1'b0;
        endcase
    end

    assign stat.pattern_ok  = pattern_ok;
    assign stat.out_free    = !out_valid_reg || m_axis_tready;
    assign stat.final_frame = final_frame;

    // bit position of the current sweep step
    assign pos_wide = rev_reg ? (n_reg - 4'd1 - inner_reg) : inner_reg;
    assign bit_sel  = 8'(1) << pos_wide[2:0];
    assign sweep_end = ((inner_reg + 4'd1) == outer_reg);

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            mask[b] = (4'(b) < n_reg);
        end
    end

    // frame and next counters for one step
    always_comb
    begin
        frame       = word_reg;
        final_frame = 1'b1;
        word_next   = word_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        case (func_reg)
            lps_pkg::FUNC_FLASH:
            begin
                frame       = word_reg ^ mask;
                word_next   = frame;
                outer_next  = outer_reg + 4'd1;
                final_frame = (outer_reg == 4'd1);
            end
            lps_pkg::FUNC_FILL:
            begin
                if (outer_reg != 4'd0)
                begin
                    frame       = word_reg ^ bit_sel;
                    final_frame = 1'b0;
                    if (sweep_end)
                    begin
                        word_next  = frame;  // last bit of a sweep stays toggled
                        inner_next = 4'd0;
                        outer_next = outer_reg - 4'd1;
                    end
                    else
                    begin
                        inner_next = inner_reg + 4'd1;
                    end
                end
            end
            lps_pkg::FUNC_EMPTY, lps_pkg::FUNC_CLIMB:
            begin
                frame       = word_reg ^ bit_sel;
                word_next   = frame;
                inner_next  = inner_reg + 4'd1;
                final_frame = ((inner_reg + 4'd1) == n_reg);
            end
            lps_pkg::FUNC_TRAVEL:
            begin
                if (inner_reg != n_reg)
                begin
                    frame       = word_reg ^ bit_sel;
                    final_frame = 1'b0;
                    inner_next  = inner_reg + 4'd1;
                end
            end
            default: final_frame = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (in_load)
                begin
                    word_reg <= in_start;
                end
                outer_reg <= (in_func == lps_pkg::FUNC_FILL) ? in_n : 4'd0;
                inner_reg <= 4'd0;
            end
            else if (cmd.step)
            begin
                word_reg  <= word_next;
                outer_reg <= outer_next;
                inner_reg <= inner_next;
            end

            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= in_func;
            rev_reg  <= in_reverse;
            n_reg    <= in_n;
        end
        if (cmd.step)
        begin
            out_leds_reg <= frame;
            out_last_reg <= final_frame;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_leds_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> hw/rtl/led_pattern_sequencer.sv
// ============================================================================
// led_pattern_sequencer - LED pattern sequencer top level
// Takes pattern commands and streams out every displayed LED frame.
// ============================================================================
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: func, reverse, width,
//           |     |                              |        load, start_value
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: leds; tlast: last
//
//  Flow: a command beat is taken first, then one frame per cycle while the
//  output side takes beats (fill over eight LEDs: 37 frames); the frame
//  counters of the datapath set the frame count. Unused pattern codes give
//  no frames.
//  Reset: rst_n clears the kept LED word, the counters and the output valid.
//  Stalls: a low m_axis_tready holds the frame in the output register and
//  freezes stepping; s_axis_tready is high only between commands.
//
module led_pattern_sequencer
#(
    parameter int LED_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] func, [3] reverse, [7:4] width,
                                        // [8] load, [16:9] start_value, rest 0
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] leds
    output logic        m_axis_tlast
);

    lps_pkg::lps_cmd_t  cmd;
    lps_pkg::lps_stat_t stat;

    // sequencing: idle / run
    lps_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // LED word, sweep counters, output register
    lps_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> tb/sv/led_pattern_sequencer_test.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer_test - self-checking bench for the LED pattern sequencer
// Streams pattern commands into the block and checks each displayed frame
// against a cycle-free model of the patterns or typed LED words. A short
// table of directed commands comes first, then phases of random commands.
// Both stream sides idle at random, and some phases do not idle at all.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LedCount    = 8;
    // widths saturate at the LED count and never go past the word
    localparam int LedLimit    = (LedCount < lps_pkg::WordBits) ? LedCount
                                                                : lps_pkg::WordBits;
    localparam int CycleLimit  = 2_000_000;
    localparam int DrainCycles = 40;
    localparam int PhaseItems  = 120;

    // pattern codes the block does not implement: no frames, load still applies
    localparam logic [2:0] FUNC_SPARE_A = 3'd5;
    localparam logic [2:0] FUNC_SPARE_B = 3'd6;
    localparam logic [2:0] FUNC_SPARE_C = 3'd7;

    typedef struct {
        logic [2:0] func;
        logic       reverse;
        logic [3:0] width;
        logic       load;
        logic [7:0] start_value;
    } pattern_cmd_t;

    typedef struct {
        logic [7:0] leds;
        logic       last;
    } led_frame_t;

    // directed row: frames < 0 means the frames come from the pattern model,
    // otherwise frames (0 to 2) and the typed LED words are what must show
    typedef struct {
        pattern_cmd_t cmd;
        int           frames;
        logic [7:0]   leds0;
        logic [7:0]   leds1;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [2:0] func, [3] reverse, [7:4] width,
                                        // [8] load, [16:9] start_value, rest 0
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] leds
    logic        m_axis_tlast;

    led_frame_t      pending_frames[$];   // frames still owed by the block
    led_frame_t      cmd_frames[$];       // frames of the command just predicted
    directed_row_t   directed_rows[$];
    logic [7:0]      led_state = '0;      // kept LED word of the model
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              stall_left = 0;
    bit              send_calm = 1'b0;
    bit              recv_calm = 1'b0;

    led_pattern_sequencer #(
        .LED_COUNT(LedCount)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // watchdog: a hung block or a lost frame ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void show_frame();
        led_frame_t f;
        f.leds = led_state;
        f.last = 1'b0;
        cmd_frames.push_back(f);
    endfunction

    // Pattern model: every frame is the kept word after bit toggles.
    // Leaves the frames of one command in cmd_frames, last flag on the final one.
    function automatic void predict_frames(input pattern_cmd_t c);
        int n;
        int outer;
        int k;
        int p;
        cmd_frames.delete();
        if (c.load)
            led_state = c.start_value;
        n = c.width;
        if (n == 0 || n > LedLimit)
            n = LedLimit;
        case (c.func)
            lps_pkg::FUNC_FLASH:
            begin
                // direction plays no part: invert the low n bits, twice
                repeat (2)
                begin
                    for (k = 0; k < n; k++)
                        led_state[k] = ~led_state[k];
                    show_frame();
                end
            end
            lps_pkg::FUNC_FILL:
            begin
                // shrinking sweeps; the bit at the end of each sweep stays toggled
                for (outer = n; outer > 0; outer--)
                begin
                    for (k = 0; k < outer; k++)
                    begin
                        p = c.reverse ? n - 1 - k : k;
                        led_state[p] = ~led_state[p];
                        show_frame();
                        if (k + 1 < outer)
                            led_state[p] = ~led_state[p];
                    end
                end
                show_frame();
            end
            lps_pkg::FUNC_EMPTY, lps_pkg::FUNC_CLIMB:
            begin
                for (k = 0; k < n; k++)
                begin
                    p = c.reverse ? n - 1 - k : k;
                    led_state[p] = ~led_state[p];
                    show_frame();
                end
            end
            lps_pkg::FUNC_TRAVEL:
            begin
                // one toggled bit walks across, the word is restored behind it
                for (k = 0; k < n; k++)
                begin
                    p = c.reverse ? n - 1 - k : k;
                    led_state[p] = ~led_state[p];
                    show_frame();
                    led_state[p] = ~led_state[p];
                end
                show_frame();
            end
            default: ;
        endcase
        if (cmd_frames.size() > 0)
            cmd_frames[cmd_frames.size() - 1].last = 1'b1;
    endfunction

    // One command beat: optional idle, then hold tvalid until the block takes it.
    // The owed frames are queued at the edge that accepts the beat.
    task automatic send_cmd(input pattern_cmd_t c, input int frames,
                            input logic [7:0] leds0, input logic [7:0] leds1);
        int gap;
        led_frame_t f;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {7'd0, c.start_value, c.load, c.width, c.reverse, c.func};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_frames(c);
        if (frames >= 0)
        begin
            // directed row with frames typed in: those replace the model's
            cmd_frames.delete();
            if (frames > 0)
            begin
                f.leds = leds0;
                f.last = (frames == 1);
                cmd_frames.push_back(f);
            end
            if (frames > 1)
            begin
                f.leds = leds1;
                f.last = 1'b1;
                cmd_frames.push_back(f);
            end
        end
        foreach (cmd_frames[i])
            pending_frames.push_back(cmd_frames[i]);
    endtask

    task automatic add_row(input logic [2:0] func, input logic reverse,
                           input logic [3:0] width, input logic load,
                           input logic [7:0] start_value, input int frames,
                           input logic [7:0] leds0, input logic [7:0] leds1);
        directed_row_t r;
        r.cmd.func        = func;
        r.cmd.reverse     = reverse;
        r.cmd.width       = width;
        r.cmd.load        = load;
        r.cmd.start_value = start_value;
        r.frames          = frames;
        r.leds0           = leds0;
        r.leds1           = leds1;
        directed_rows.push_back(r);
    endtask

    // Frame checker and output-side stall generator. Every frame beat is
    // compared with the oldest owed frame, field by field.
    always @(posedge clk)
    begin
        led_frame_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_frames.size() == 0)
                report_mismatch($sformatf("frame %02h last %0b with none owed",
                                          m_axis_tdata, m_axis_tlast));
            else
            begin
                want = pending_frames.pop_front();
                if (m_axis_tdata !== want.leds)
                    report_mismatch($sformatf("leds %02h, want %02h",
                                              m_axis_tdata, want.leds));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b on leds %02h, want %0b",
                                              m_axis_tlast, m_axis_tdata, want.last));
            end
        end
        if (stall_left == 0)
            stall_left = pick_gap(recv_calm);
        else
            stall_left = stall_left - 1;
        m_axis_tready <= (stall_left == 0);
    end

    initial
    begin
        pattern_cmd_t c;
        int r;
        int phase;
        int drain;

        // Directed table. Typed frames follow the kept word from reset.
        // flash over all LEDs from a cleared word
        add_row(lps_pkg::FUNC_FLASH, 1'b0, 4'd8, 1'b0, 8'h00, 2, 8'hff, 8'h00);
        // width zero means all LEDs
        add_row(lps_pkg::FUNC_FLASH, 1'b0, 4'd0, 1'b1, 8'ha5, 2, 8'h5a, 8'ha5);
        // width above the LED count saturates
        add_row(lps_pkg::FUNC_FLASH, 1'b0, 4'd15, 1'b1, 8'h00, 2, 8'hff, 8'h00);
        // flash ignores direction, upper nibble untouched
        add_row(lps_pkg::FUNC_FLASH, 1'b1, 4'd4, 1'b1, 8'hf0, 2, 8'hff, 8'hf0);
        // unused codes: no frames, but the load sticks
        add_row(FUNC_SPARE_A, 1'b0, 4'd3, 1'b1, 8'h3c, 0, 8'h00, 8'h00);
        add_row(FUNC_SPARE_C, 1'b1, 4'd8, 1'b0, 8'h00, 0, 8'h00, 8'h00);
        add_row(FUNC_SPARE_B, 1'b0, 4'd0, 1'b1, 8'hff, 0, 8'h00, 8'h00);
        // single-LED sweeps
        add_row(lps_pkg::FUNC_EMPTY, 1'b0, 4'd1, 1'b1, 8'h00, 1, 8'h01, 8'h00);
        add_row(lps_pkg::FUNC_FILL, 1'b1, 4'd1, 1'b0, 8'h00, 2, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_TRAVEL, 1'b0, 4'd1, 1'b1, 8'h80, 2, 8'h81, 8'h80);
        // further patterns, checked against the model
        add_row(lps_pkg::FUNC_FILL, 1'b0, 4'd8, 1'b1, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_FILL, 1'b1, 4'd0, 1'b1, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_EMPTY, 1'b0, 4'd8, 1'b1, 8'hff, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_EMPTY, 1'b1, 4'd8, 1'b0, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_CLIMB, 1'b0, 4'd8, 1'b1, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_CLIMB, 1'b1, 4'd3, 1'b0, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_TRAVEL, 1'b0, 4'd8, 1'b1, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_TRAVEL, 1'b1, 4'd12, 1'b1, 8'h55, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_FILL, 1'b1, 4'd5, 1'b1, 8'haa, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_CLIMB, 1'b0, 4'd9, 1'b0, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_EMPTY, 1'b0, 4'd2, 1'b1, 8'h81, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_TRAVEL, 1'b1, 4'd0, 1'b0, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_FILL, 1'b0, 4'd15, 1'b0, 8'h00, -1, 8'h00, 8'h00);
        add_row(lps_pkg::FUNC_FLASH, 1'b0, 4'd1, 1'b1, 8'hff, -1, 8'h00, 8'h00);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].frames,
                     directed_rows[i].leds0, directed_rows[i].leds1);

        // Random phases; each side idles in some phases and runs flat out
        // in others.
        for (phase = 0; phase < 4; phase++)
        begin
            send_calm = (phase == 1) || (phase == 3);
            recv_calm = (phase == 2) || (phase == 3);
            repeat (PhaseItems)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    c.func = 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
                else
                    c.func = 3'($urandom_range(lps_pkg::FUNC_FLASH,
                                               lps_pkg::FUNC_CLIMB));
                c.reverse = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if (r < 10)
                    c.width = 4'd0;
                else if (r < 20)
                    c.width = 4'($urandom_range(9, 15));
                else
                    c.width = 4'($urandom_range(1, 8));
                c.load        = 1'($urandom_range(0, 1));
                c.start_value = 8'($urandom_range(0, 255));
                send_cmd(c, -1, 8'h00, 8'h00);
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the owed frames drain, then a quiet spell for anything extra
        while (pending_frames.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DrainCycles; drain++)
            @(posedge clk);

        if (mismatch_count == 0 && pending_frames.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lps_pkg.sv
hw/rtl/lps_ctrl.sv
hw/rtl/lps_dp.sv
hw/rtl/led_pattern_sequencer.sv
tb/sv/led_pattern_sequencer_test.sv
